@@ rtl/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and constants of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned LANES      = 4;
  localparam int unsigned PROD_W     = 2 * WORD_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned RND_W      = SUM_W - FRAC_BITS;
  localparam int unsigned SQ_W       = PROD_W - 1;
  localparam int unsigned RAD_W      = PROD_W;
  localparam int unsigned ROOT_W     = WORD_W + 1;
  localparam int unsigned SQRT_STEPS = WORD_W;
  localparam int unsigned SQRT_LAT   = SQRT_STEPS + 1;
  localparam int unsigned QUO_W      = 30;
  localparam int unsigned NUM_W      = WORD_W + FRAC_BITS;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned LANE_LAT   = 3;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [RAD_W-1:0]  ONE_SQ   = RAD_W'(1) << (2 * FRAC_BITS);
  localparam logic [SUM_W-1:0]  RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [ROOT_W-1:0] ROOT_CARRY = ROOT_W'(1) << WORD_W;

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_NORM = 2'd1,
    CMD_CONJ = 2'd2,
    CMD_EXT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_NEG_ROOT  = 2'd2,
    ST_SAT       = 2'd3
  } status_e;

  // Hamilton product: lane i, term j uses a[MUL_A_IDX[i][j]] * b[j]
  localparam logic [1:0] MUL_A_IDX [LANES][LANES] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic [LANES-1:0] MUL_NEG [LANES] = '{
    4'b1110, 4'b0100, 4'b1000, 4'b0010
  };

  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0] op_a;
    logic [LANES-1:0][WORD_W-1:0] op_b;
    logic [LANES-1:0]             neg;
    logic                         use_sum;
    logic [WORD_W-1:0]            bypass;
    logic                         bypass_sat;
  } lane_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              sat;
    logic [SQ_W-1:0]   square;
  } lane_rsp_t;

  typedef struct packed {
    cmd_e                         cmd;
    logic [LANES-1:0][WORD_W-1:0] val;
    logic [LANES-1:0]             sat;
    logic                         zero;
    logic                         carry;
    logic                         neg;
  } side_t;

endpackage

@@ rtl/quaternion_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Multiply, normalize, conjugate and extend of Q3.28 quaternions.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle. Every request passes through the
// 33-stage square root and the 30-stage divider, after four product lanes
// and the merge of their squares. The whole pipeline holds while a result
// waits in the output register.
module quaternion_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [1:0]   s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // r_w, r_x, r_y, r_z
  output logic [1:0]   m_axis_tuser   // status
);

  localparam int unsigned W     = qau_pkg::WORD_W;
  localparam int unsigned L     = qau_pkg::LANES;
  localparam int unsigned DEPTH = qau_pkg::LANE_LAT + 2 + qau_pkg::SQRT_LAT + 1 +
                                  qau_pkg::DIV_STEPS;

  logic                adv;
  logic [DEPTH-1:0]    vld_q;
  logic                out_vld_q;
  logic [127:0]        out_data_q, out_data_d;
  logic [1:0]          out_user_q, out_user_d;

  logic [W-1:0]        a_in [L];
  logic [W-1:0]        b_in [L];
  qau_pkg::cmd_e       cmd_in;
  qau_pkg::lane_req_t  lane_req [L];
  qau_pkg::lane_rsp_t  lane_rsp [L];
  qau_pkg::cmd_e       cmd_l_q [qau_pkg::LANE_LAT];

  logic [qau_pkg::SQ_W+1:0]    sq4_q;
  logic [qau_pkg::RAD_W-1:0]   sq3_q;
  qau_pkg::side_t              m1_side_q, m2_side_q;
  logic [qau_pkg::RAD_W-1:0]   rad_q;
  logic [qau_pkg::ROOT_W-1:0]  root;
  qau_pkg::side_t              sq_side_q [qau_pkg::SQRT_LAT];

  logic [qau_pkg::ROOT_W-1:0]  den_q;
  logic [qau_pkg::NUM_W-1:0]   num_q [L];
  logic [qau_pkg::ROOT_W-1:0]  d0_root_q;
  qau_pkg::side_t              d0_side_q;
  logic [qau_pkg::QUO_W-1:0]   quo [L];
  qau_pkg::side_t              dv_side_q [qau_pkg::DIV_STEPS];
  logic [qau_pkg::ROOT_W-1:0]  dv_root_q [qau_pkg::DIV_STEPS];

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cmd_in        = qau_pkg::cmd_e'(s_axis_tuser);

  always_comb begin
    for (int i = 0; i < L; i++) begin
      a_in[i] = s_axis_tdata[i*W +: W];
      b_in[i] = s_axis_tdata[(L+i)*W +: W];
    end
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      lane_req[i].use_sum    = (cmd_in == qau_pkg::CMD_MUL);
      lane_req[i].bypass     = a_in[i];
      lane_req[i].bypass_sat = 1'b0;
      if (cmd_in == qau_pkg::CMD_MUL) begin
        lane_req[i].neg = qau_pkg::MUL_NEG[i];
        for (int j = 0; j < L; j++) begin
          lane_req[i].op_a[j] = a_in[qau_pkg::MUL_A_IDX[i][j]];
          lane_req[i].op_b[j] = b_in[j];
        end
      end else begin
        lane_req[i].neg = '0;
        for (int j = 0; j < L; j++) begin
          lane_req[i].op_a[j] = (j == 0) ? a_in[i] : '0;
          lane_req[i].op_b[j] = (j == 0) ? a_in[i] : '0;
        end
      end
      if (cmd_in == qau_pkg::CMD_CONJ && i != 0) begin
        if (a_in[i] == qau_pkg::WORD_MIN) begin
          lane_req[i].bypass     = qau_pkg::WORD_MAX;
          lane_req[i].bypass_sat = 1'b1;
        end else begin
          lane_req[i].bypass = ~a_in[i] + W'(1);
        end
      end
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_lane
    qau_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .req_i (lane_req[g]),
      .rsp_o (lane_rsp[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[DEPTH-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[DEPTH-1];
    end
  end

  // merge lanes: sum of squares, then radicand and flags
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_l_q[0] <= cmd_in;
      for (int k = 1; k < qau_pkg::LANE_LAT; k++) begin
        cmd_l_q[k] <= cmd_l_q[k-1];
      end
      sq4_q <= (qau_pkg::SQ_W+2)'(lane_rsp[0].square) +
               (qau_pkg::SQ_W+2)'(lane_rsp[1].square) +
               (qau_pkg::SQ_W+2)'(lane_rsp[2].square) +
               (qau_pkg::SQ_W+2)'(lane_rsp[3].square);
      sq3_q <= qau_pkg::RAD_W'(lane_rsp[1].square) +
               qau_pkg::RAD_W'(lane_rsp[2].square) +
               qau_pkg::RAD_W'(lane_rsp[3].square);
      m1_side_q.cmd   <= cmd_l_q[qau_pkg::LANE_LAT-1];
      for (int i = 0; i < L; i++) begin
        m1_side_q.val[i] <= lane_rsp[i].value;
        m1_side_q.sat[i] <= lane_rsp[i].sat;
      end
      m1_side_q.zero  <= 1'b0;
      m1_side_q.carry <= 1'b0;
      m1_side_q.neg   <= 1'b0;

      m2_side_q.cmd   <= m1_side_q.cmd;
      m2_side_q.val   <= m1_side_q.val;
      m2_side_q.sat   <= m1_side_q.sat;
      m2_side_q.zero  <= (m1_side_q.cmd == qau_pkg::CMD_NORM) && (sq4_q == '0);
      m2_side_q.carry <= sq4_q[qau_pkg::SQ_W+1];
      m2_side_q.neg   <= (m1_side_q.cmd == qau_pkg::CMD_EXT) && (sq3_q > qau_pkg::ONE_SQ);
      rad_q <= (m1_side_q.cmd == qau_pkg::CMD_EXT) ? (qau_pkg::ONE_SQ - sq3_q)
                                                   : sq4_q[qau_pkg::RAD_W-1:0];
    end
  end

  qau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_side_q[0] <= m2_side_q;
      for (int k = 1; k < qau_pkg::SQRT_LAT; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [qau_pkg::ROOT_W-1:0] den;
    logic [W-1:0]               mag;
    if (adv) begin
      if (sq_side_q[qau_pkg::SQRT_LAT-1].carry) begin
        den = qau_pkg::ROOT_CARRY;
      end else if (root == '0) begin
        den = qau_pkg::ROOT_W'(1);
      end else begin
        den = root;
      end
      for (int i = 0; i < L; i++) begin
        mag = sq_side_q[qau_pkg::SQRT_LAT-1].val[i][W-1]
              ? (~sq_side_q[qau_pkg::SQRT_LAT-1].val[i] + W'(1))
              : sq_side_q[qau_pkg::SQRT_LAT-1].val[i];
        num_q[i] <= {mag, {qau_pkg::FRAC_BITS{1'b0}}} +
                    qau_pkg::NUM_W'(den[qau_pkg::ROOT_W-1:1]);
      end
      den_q     <= den;
      d0_root_q <= root;
      d0_side_q <= sq_side_q[qau_pkg::SQRT_LAT-1];
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_div
    qau_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[g]),
      .den_i (den_q),
      .quo_o (quo[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= d0_side_q;
      dv_root_q[0] <= d0_root_q;
      for (int k = 1; k < qau_pkg::DIV_STEPS; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
        dv_root_q[k] <= dv_root_q[k-1];
      end
    end
  end

  always_comb begin
    qau_pkg::side_t sd;
    logic [W-1:0]   qx;
    logic [W-1:0]   r [L];
    sd = dv_side_q[qau_pkg::DIV_STEPS-1];
    for (int i = 0; i < L; i++) begin
      qx   = W'(quo[i]);
      r[i] = sd.val[i];
      if (sd.cmd == qau_pkg::CMD_NORM && !sd.zero) begin
        r[i] = sd.val[i][W-1] ? (~qx + W'(1)) : qx;
      end
    end
    if (sd.cmd == qau_pkg::CMD_EXT) begin
      r[0] = sd.neg ? '0 : dv_root_q[qau_pkg::DIV_STEPS-1][W-1:0];
    end
    out_data_d = {r[3], r[2], r[1], r[0]};
    priority if (|sd.sat) begin
      out_user_d = qau_pkg::ST_SAT;
    end else if (sd.cmd == qau_pkg::CMD_NORM && sd.zero) begin
      out_user_d = qau_pkg::ST_ZERO_NORM;
    end else if (sd.cmd == qau_pkg::CMD_EXT && sd.neg) begin
      out_user_d = qau_pkg::ST_NEG_ROOT;
    end else begin
      out_user_d = qau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/qau_lane.sv @@
// ----------------------------------------------------------------------------
// qau_lane
// One component lane: four products, signed sum, rounding and saturation, or a bypass value.
// ----------------------------------------------------------------------------
module qau_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  qau_pkg::lane_req_t  req_i,
  output qau_pkg::lane_rsp_t  rsp_o
);

  logic signed [qau_pkg::PROD_W-1:0] prod_q [qau_pkg::LANES];
  logic [qau_pkg::LANES-1:0]         neg_q;
  logic                              use_sum_q, use_sum2_q;
  logic [qau_pkg::WORD_W-1:0]        byp_q, byp2_q;
  logic                              bsat_q, bsat2_q;
  logic signed [qau_pkg::SUM_W-1:0]  sum_d, sum_q;
  logic [qau_pkg::SQ_W-1:0]          sq_q;
  logic [qau_pkg::SUM_W-1:0]         rnd;
  logic [qau_pkg::RND_W-1:0]         sh;
  logic                              ovf;
  qau_pkg::lane_rsp_t                rsp_d, rsp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < qau_pkg::LANES; j++) begin
        prod_q[j] <= $signed(req_i.op_a[j]) * $signed(req_i.op_b[j]);
      end
      neg_q     <= req_i.neg;
      use_sum_q <= req_i.use_sum;
      byp_q     <= req_i.bypass;
      bsat_q    <= req_i.bypass_sat;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < qau_pkg::LANES; j++) begin
      if (neg_q[j]) begin
        sum_d = sum_d - qau_pkg::SUM_W'(prod_q[j]);
      end else begin
        sum_d = sum_d + qau_pkg::SUM_W'(prod_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q      <= sum_d;
      sq_q       <= prod_q[0][qau_pkg::SQ_W-1:0];
      use_sum2_q <= use_sum_q;
      byp2_q     <= byp_q;
      bsat2_q    <= bsat_q;
    end
  end

  always_comb begin
    rnd = sum_q + qau_pkg::RND_HALF;
    sh  = rnd[qau_pkg::SUM_W-1:qau_pkg::FRAC_BITS];
    ovf = !((&sh[qau_pkg::RND_W-1:qau_pkg::WORD_W-1]) ||
            !(|sh[qau_pkg::RND_W-1:qau_pkg::WORD_W-1]));
    rsp_d.square = sq_q;
    if (use_sum2_q) begin
      rsp_d.sat = ovf;
      if (ovf) begin
        rsp_d.value = sh[qau_pkg::RND_W-1] ? qau_pkg::WORD_MIN : qau_pkg::WORD_MAX;
      end else begin
        rsp_d.value = sh[qau_pkg::WORD_W-1:0];
      end
    end else begin
      rsp_d.sat   = bsat2_q;
      rsp_d.value = byp2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ rtl/qau_sqrt.sv @@
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined square root, two radicand bits per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module qau_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qau_pkg::RAD_W-1:0]   rad_i,
  output logic [qau_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned S     = qau_pkg::SQRT_STEPS;
  localparam int unsigned REM_W = qau_pkg::WORD_W + 3;

  logic [REM_W-1:0]           rem_in [S], rem_d [S], rem_q [S];
  logic [qau_pkg::WORD_W-1:0] rt_in  [S], rt_d  [S], rt_q  [S];
  logic [qau_pkg::RAD_W-1:0]  rad_in [S], rad_d [S], rad_q [S];
  logic [qau_pkg::ROOT_W-1:0] res_q;

  always_comb begin
    rem_in[0] = '0;
    rt_in[0]  = '0;
    rad_in[0] = rad_i;
    for (int k = 1; k < S; k++) begin
      rem_in[k] = rem_q[k-1];
      rt_in[k]  = rt_q[k-1];
      rad_in[k] = rad_q[k-1];
    end
  end

  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fits;
    for (int k = 0; k < S; k++) begin
      cur   = {rem_in[k][REM_W-3:0], rad_in[k][qau_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, rt_in[k], 2'b01};
      fits  = (cur >= trial);
      rem_d[k] = fits ? (cur - trial) : cur;
      rt_d[k]  = {rt_in[k][qau_pkg::WORD_W-2:0], fits};
      rad_d[k] = {rad_in[k][qau_pkg::RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < S; k++) begin
        rem_q[k] <= rem_d[k];
        rt_q[k]  <= rt_d[k];
        rad_q[k] <= rad_d[k];
      end
      res_q <= {1'b0, rt_q[S-1]} +
               qau_pkg::ROOT_W'(rem_q[S-1] > {3'b000, rt_q[S-1]});
    end
  end

  assign root_o = res_q;

endmodule

@@ rtl/qau_div.sv @@
// ----------------------------------------------------------------------------
// qau_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qau_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qau_pkg::NUM_W-1:0]   num_i,
  input  logic [qau_pkg::ROOT_W-1:0]  den_i,
  output logic [qau_pkg::QUO_W-1:0]   quo_o
);

  localparam int unsigned S     = qau_pkg::DIV_STEPS;
  localparam int unsigned REM_W = qau_pkg::ROOT_W;
  localparam int unsigned LO_W  = qau_pkg::QUO_W;

  logic [REM_W-1:0]           rem_in [S], rem_d [S], rem_q [S];
  logic [LO_W-1:0]            lo_in  [S], lo_d  [S], lo_q  [S];
  logic [qau_pkg::ROOT_W-1:0] den_in [S], den_q [S];

  always_comb begin
    rem_in[0] = REM_W'(num_i[qau_pkg::NUM_W-1:LO_W]);
    lo_in[0]  = num_i[LO_W-1:0];
    den_in[0] = den_i;
    for (int k = 1; k < S; k++) begin
      rem_in[k] = rem_q[k-1];
      lo_in[k]  = lo_q[k-1];
      den_in[k] = den_q[k-1];
    end
  end

  always_comb begin
    logic [REM_W:0] cur;
    logic [REM_W:0] diff;
    logic           ge;
    for (int k = 0; k < S; k++) begin
      cur  = {rem_in[k], lo_in[k][LO_W-1]};
      diff = cur - {1'b0, den_in[k]};
      ge   = (cur >= {1'b0, den_in[k]});
      rem_d[k] = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      lo_d[k]  = {lo_in[k][LO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < S; k++) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo_o = lo_q[S-1];

endmodule
